// ----- design/scalar_vector_quantizer_defines.svh -----
// assertion macros for the scalar vector quantizer
// no dependencies; included by the modules that carry checks
`ifndef SCALAR_VECTOR_QUANTIZER_DEFINES_SVH
`define SCALAR_VECTOR_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SVQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SVQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SVQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SVQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/svq_pkg.sv -----
// shared types, codes and constants of the scalar vector quantizer
// no dependencies
package svq_pkg;

   localparam int MAX_DIMS_DEF   = 1024;
   localparam int SCALE_FRAC_DEF = 32;
   localparam int SCALE_W        = 48;
   localparam int DIMS_W         = 11;
   localparam logic [DIMS_W-1:0] DIMS_RESET = 11'd1024;

   // command codes
   localparam logic [2:0] CMD_BEGIN  = 3'd0;
   localparam logic [2:0] CMD_TRAIN  = 3'd1;
   localparam logic [2:0] CMD_FINISH = 3'd2;
   localparam logic [2:0] CMD_ENCODE = 3'd3;
   localparam logic [2:0] CMD_DECODE = 3'd4;
   localparam logic [2:0] CMD_DIST   = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_CODE  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_DIST  = 2'd2;

   // operand pairs of the shared distance multiplier
   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_HI_LO = 2'd1;
   localparam logic [1:0] MUL_HI_HI = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [9:0]         dim_index;
      logic signed [31:0] sample;
      logic [7:0]         code_a;
      logic [7:0]         code_b;
      logic               last;
   } svq_req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         code;
      logic signed [31:0] value;
      logic [63:0]        distance;
   } svq_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       use_cnt;
      logic       cnt_inc;
      logic       clr_wr;
      logic       init_wr;
      logic       train_wr;
      logic       fin_cap;
      logic       fin_wr;
      logic       enc_cap;
      logic       enc_out;
      logic       dec_mul;
      logic       dec_out;
      logic       dist_p;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       acc_load;
      logic       acc_add1;
      logic       acc_add2;
      logic       dist_sum;
      logic       dist_out;
   } svq_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_at_max;
      logic cnt_at_eff;
      logic div_done;
      logic seen;
   } svq_stat_type;

endpackage

// ----- design/svq_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module svq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/svq_div.sv -----
// restoring divider, one quotient bit per cycle
// no dependencies
module svq_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             bit_in;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      bit_in  = (rem_sh >= {1'b0, den_ff});
   end

   // iteration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient and remainder
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], bit_in};
         rem_ff <= bit_in ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- design/svq_datapath.sv -----
// datapath: tables, divider, multipliers, accumulators and result register
// depends on svq_pkg, svq_ram, svq_div and the assertion macro header
`include "scalar_vector_quantizer_defines.svh"
module svq_datapath import svq_pkg::*; #(
   parameter int MAX_DIMS        = MAX_DIMS_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  svq_ctl_type       ctl,
   output svq_stat_type      stat,
   input  svq_req_type       req_data,
   input  logic              csr_wr_en,
   input  logic [DIMS_W-1:0] csr_wr_data,
   output logic              rsp_strobe,
   output svq_rsp_type       rsp_data
);

   localparam int AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CW  = $clog2(MAX_DIMS + 1);
   localparam int SH  = SCALE_FRAC_BITS - 16;
   localparam int NW  = ((SCALE_FRAC_BITS + 17) > SCALE_W ? SCALE_FRAC_BITS + 17 : SCALE_W) + 1;
   localparam int DW  = SCALE_W + 1;
   localparam int PW  = 8 + SCALE_W;
   localparam int QW  = 2 * PW;
   localparam int DS  = 2 * SCALE_FRAC_BITS - 32;
   localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << SCALE_FRAC_BITS;
   localparam logic [SCALE_W-1:0] SCALE_MASK = '1;
   localparam logic [PW:0] DEC_HALF  = ((PW + 1)'(1) << SH) >> 1;
   localparam logic [QW:0] DIST_HALF = ((QW + 1)'(1) << DS) >> 1;
   // finish step: range*2^SH = 255*FIN_K*range + 2^FIN_E*range
   localparam int FIN_E = SH % 8;
   localparam logic [23:0] FIN_K =
      24'((((64'd1 << SH) - (64'd1 << FIN_E)) / 64'd255));
   // inverse of 255 modulo 2^32, for exact division
   localparam logic [31:0] INV255 = 32'hFEFE_FEFF;

   svq_req_type        item_ff;
   logic [DIMS_W-1:0]  dims_ff;
   logic [AW-1:0]      cnt_ff;
   logic               seen_ff;
   logic signed [31:0] fin_min_ff;
   logic               fin_pos_ff;
   logic [31:0]        fin_range_ff;
   logic [39:0]        fin_y_ff;
   logic [39:0]        fin_ex_ff;
   logic [55:0]        fin_kr_ff;
   logic [31:0]        fin_q_ff;
   logic               fin_v1_ff;
   logic               fin_v2_ff;
   logic               enc_ok_ff;
   logic [PW-1:0]      dec_p_ff;
   logic [PW-1:0]      p_ff;
   logic [63:0]        mul_ff;
   logic [QW-1:0]      acc_ff;
   logic [63:0]        dist_acc_ff;
   logic               rsp_strobe_ff;
   svq_rsp_type        rsp_data_ff;

   logic [CW-1:0]        eff;
   logic                 in_eff;
   logic                 inmax;
   logic [AW-1:0]        addr;
   logic signed [31:0]   min_rd;
   logic [SCALE_W-1:0]   scale_rd;
   logic signed [31:0]   rmin_rd;
   logic signed [31:0]   rmax_rd;
   logic signed [31:0]   mn_eff;
   logic [SCALE_W-1:0]   sc_eff;
   logic                 tab_we;
   logic                 run_we;
   logic [31:0]          min_wd;
   logic [SCALE_W-1:0]   scale_wd;
   logic [SCALE_W-1:0]   fin_scale;
   logic signed [31:0]   new_min;
   logic signed [31:0]   new_max;
   logic [31:0]          rmin_wd;
   logic [31:0]          rmax_wd;
   logic signed [32:0]   range;
   logic signed [32:0]   diff;
   logic [39:0]          fin_y;
   logic [10:0]          fin_bsum;
   logic [8:0]           fin_f1;
   logic [7:0]           fin_f2;
   logic [7:0]           fin_rem;
   logic [31:0]          fin_prod;
   logic [56:0]          fin_tot;
   logic [NW-1:0]        enc_num;
   logic [NW-1:0]        div_num;
   logic [DW-1:0]        div_den;
   logic                 div_start;
   logic                 div_done;
   logic [NW-1:0]        quot;
   logic [7:0]           enc_code;
   logic [PW:0]          dec_rnd;
   logic [PW:0]          dec_shr;
   logic [31:0]          dec_p32;
   logic signed [33:0]   dec_sum;
   logic [31:0]          dec_val;
   logic [7:0]           ad;
   logic [31:0]          a0;
   logic [31:0]          a1;
   logic [31:0]          mul_x;
   logic [31:0]          mul_y;
   logic [QW:0]          dist_rnd;
   logic [QW:0]          dist_shr;
   logic [63:0]          term;
   logic [64:0]          sum;
   logic [63:0]          new_acc;
   logic                 emit_dist;

   // effective dimension count, clamped to one..max
   always_comb begin
      if (dims_ff == '0) begin
         eff = CW'(1);
      end else if (32'(dims_ff) > MAX_DIMS) begin
         eff = CW'(MAX_DIMS);
      end else begin
         eff = CW'(dims_ff);
      end
      in_eff          = (32'(item_ff.dim_index) < 32'(eff));
      inmax           = (32'(item_ff.dim_index) < MAX_DIMS);
      stat.cnt_at_max = (32'(cnt_ff) == MAX_DIMS - 1);
      stat.cnt_at_eff = (32'(cnt_ff) == 32'(eff) - 1);
      stat.div_done   = div_done | fin_v2_ff;
      stat.seen       = seen_ff;
      addr            = ctl.use_cnt ? cnt_ff : AW'(item_ff.dim_index);
   end

   // tables
   svq_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_min_ram (
      .clock(clock), .we(tab_we), .addr(addr), .wdata(min_wd), .rdata(min_rd));
   svq_ram #(.WIDTH(SCALE_W), .DEPTH(MAX_DIMS)) u_scale_ram (
      .clock(clock), .we(tab_we), .addr(addr), .wdata(scale_wd), .rdata(scale_rd));
   svq_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_rmin_ram (
      .clock(clock), .we(run_we), .addr(addr), .wdata(rmin_wd), .rdata(rmin_rd));
   svq_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_rmax_ram (
      .clock(clock), .we(run_we), .addr(addr), .wdata(rmax_wd), .rdata(rmax_rd));

   // table read values, zero beyond the table
   always_comb begin
      mn_eff = inmax ? min_rd : 32'sd0;
      sc_eff = inmax ? scale_rd : '0;
   end

   // training: running min and max
   always_comb begin
      new_min = (item_ff.sample < rmin_rd) ? item_ff.sample : rmin_rd;
      new_max = (item_ff.sample > rmax_rd) ? item_ff.sample : rmax_rd;
      run_we  = ctl.init_wr | (ctl.train_wr & in_eff);
      rmin_wd = ctl.init_wr ? 32'h7FFF_FFFF : new_min;
      rmax_wd = ctl.init_wr ? 32'h8000_0000 : new_max;
   end

   // finish and encode operands
   always_comb begin
      range     = 33'(rmax_rd) - 33'(rmin_rd);
      diff      = 33'(item_ff.sample) - 33'(mn_eff);
      fin_y     = (40'(range[31:0]) << FIN_E) + 40'd127;
      enc_num   = (NW'(diff[31:0]) << (SH + 1)) + NW'(sc_eff);
      div_start = ctl.enc_cap;
      div_num   = enc_num;
      div_den   = DW'(sc_eff) << 1;
   end

   svq_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(quot));

   // finish step by 255: remainder from byte sums, then exact division
   always_comb begin
      fin_bsum = 11'(fin_y_ff[7:0]) + 11'(fin_y_ff[15:8]) + 11'(fin_y_ff[23:16]) +
                 11'(fin_y_ff[31:24]) + 11'(fin_y_ff[39:32]);
      fin_f1   = 9'(fin_bsum[7:0]) + 9'(fin_bsum[10:8]);
      fin_f2   = 8'(9'(fin_f1[7:0]) + 9'(fin_f1[8]));
      fin_rem  = (fin_f2 == 8'hFF) ? 8'd0 : fin_f2;
      fin_prod = fin_ex_ff[31:0] * INV255;
      fin_tot  = 57'(fin_kr_ff) + 57'(fin_q_ff);
   end

   // finish write data, clear pass and saturated encode code
   always_comb begin
      if (!fin_pos_ff) begin
         fin_scale = SCALE_ONE;
      end else if (fin_tot == '0) begin
         fin_scale = SCALE_W'(1);
      end else if (fin_tot > 57'(SCALE_MASK)) begin
         fin_scale = SCALE_MASK;
      end else begin
         fin_scale = fin_tot[SCALE_W-1:0];
      end
      tab_we   = ctl.clr_wr | ctl.fin_wr;
      min_wd   = ctl.clr_wr ? 32'd0 : fin_min_ff;
      scale_wd = ctl.clr_wr ? '0 : fin_scale;
      if (!enc_ok_ff) begin
         enc_code = 8'd0;
      end else if (quot > NW'(255)) begin
         enc_code = 8'hFF;
      end else begin
         enc_code = quot[7:0];
      end
   end

   // decode rounding and saturation
   always_comb begin
      dec_rnd = (PW + 1)'(dec_p_ff) + DEC_HALF;
      dec_shr = dec_rnd >> SH;
      dec_p32 = (|dec_shr[PW:32]) ? 32'hFFFF_FFFF : dec_shr[31:0];
      dec_sum = 34'(mn_eff) + $signed({2'b00, dec_p32});
      dec_val = (dec_sum > 34'sd2147483647) ? 32'h7FFF_FFFF : dec_sum[31:0];
   end

   // distance term operands, rounding and saturating sum
   always_comb begin
      ad = (item_ff.code_a >= item_ff.code_b) ? item_ff.code_a - item_ff.code_b
                                              : item_ff.code_b - item_ff.code_a;
      a0 = p_ff[31:0];
      a1 = 32'(p_ff[PW-1:32]);
      case (ctl.mul_sel)
         MUL_LO_LO: begin
            mul_x = a0;
            mul_y = a0;
         end
         MUL_HI_LO: begin
            mul_x = a1;
            mul_y = a0;
         end
         MUL_HI_HI: begin
            mul_x = a1;
            mul_y = a1;
         end
         default: begin
            mul_x = a0;
            mul_y = a0;
         end
      endcase
      dist_rnd  = (QW + 1)'(acc_ff) + DIST_HALF;
      dist_shr  = dist_rnd >> DS;
      term      = (|dist_shr[QW:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : dist_shr[63:0];
      sum       = {1'b0, dist_acc_ff} + {1'b0, term};
      new_acc   = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      emit_dist = ctl.dist_out & item_ff.last;
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff       <= DIMS_RESET;
         cnt_ff        <= '0;
         seen_ff       <= 1'b0;
         dist_acc_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         fin_v1_ff     <= 1'b0;
         fin_v2_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dims_ff <= csr_wr_data;
         end
         if (ctl.load) begin
            cnt_ff <= '0;
         end else if (ctl.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (ctl.init_wr) begin
            seen_ff <= 1'b0;
         end else if (ctl.train_wr && in_eff) begin
            seen_ff <= 1'b1;
         end
         if (emit_dist) begin
            dist_acc_ff <= '0;
         end else if (ctl.dist_sum && in_eff) begin
            dist_acc_ff <= new_acc;
         end
         rsp_strobe_ff <= ctl.enc_out | ctl.dec_out | emit_dist;
         // finish step ready flag, delayed through fin_v1_ff and fin_v2_ff after capture
         fin_v1_ff     <= ctl.fin_cap;
         fin_v2_ff     <= fin_v1_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         item_ff <= req_data;
      end
      if (ctl.fin_cap) begin
         fin_min_ff   <= rmin_rd;
         fin_pos_ff   <= (range > 33'sd0);
         fin_range_ff <= range[31:0];
         fin_y_ff     <= fin_y;
      end
      fin_ex_ff <= fin_y_ff - 40'(fin_rem);
      fin_kr_ff <= 56'(FIN_K) * 56'(fin_range_ff);
      fin_q_ff  <= fin_prod;
      if (ctl.enc_cap) begin
         enc_ok_ff <= (sc_eff != '0) && (diff > 33'sd0);
      end
      if (ctl.dec_mul) begin
         dec_p_ff <= PW'(item_ff.code_a) * PW'(sc_eff);
      end
      if (ctl.dist_p) begin
         p_ff <= PW'(ad) * PW'(sc_eff);
      end
      if (ctl.mul_en) begin
         mul_ff <= 64'(mul_x) * 64'(mul_y);
      end
      if (ctl.acc_load) begin
         acc_ff <= QW'(mul_ff);
      end else if (ctl.acc_add1) begin
         acc_ff <= acc_ff + (QW'(mul_ff) << 33);
      end else if (ctl.acc_add2) begin
         acc_ff <= acc_ff + (QW'(mul_ff) << 64);
      end
      rsp_data_ff <= '0;
      if (ctl.enc_out) begin
         rsp_data_ff.result_kind <= KIND_CODE;
         rsp_data_ff.code        <= enc_code;
      end else if (ctl.dec_out) begin
         rsp_data_ff.result_kind <= KIND_VALUE;
         rsp_data_ff.value       <= dec_val;
      end else begin
         rsp_data_ff.result_kind <= KIND_DIST;
         rsp_data_ff.distance    <= dist_acc_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   `SVQ_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `SVQ_ASSERT_NEXT(a_dist_cleared, clock, reset, emit_dist, dist_acc_ff == '0)
   `SVQ_ASSERT_IMPL(a_no_two_writes, clock, reset, ctl.clr_wr, !ctl.fin_wr && !run_we)

endmodule

// ----- design/svq_ctrl.sv -----
// controller: sequences clear, training, finish, encode, decode and distance
// depends on svq_pkg and the assertion macro header
`include "scalar_vector_quantizer_defines.svh"
module svq_ctrl import svq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_cmd,
   output logic         busy,
   output svq_ctl_type  ctl,
   input  svq_stat_type stat
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_INIT, S_TR_RD, S_TR_WR,
      S_FIN_RD, S_FIN_CAP, S_FIN_WAIT, S_FIN_WR,
      S_EN_RD, S_EN_CAP, S_EN_WAIT, S_EN_OUT,
      S_DE_RD, S_DE_MUL, S_DE_OUT,
      S_DI_RD, S_DI_P, S_DI_M0, S_DI_M1, S_DI_M2, S_DI_ACC, S_DI_SUM, S_DI_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff && (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.cnt_at_max) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_BEGIN:  state_in = S_INIT;
                  CMD_TRAIN:  state_in = S_TR_RD;
                  CMD_FINISH: state_in = stat.seen ? S_FIN_RD : S_IDLE;
                  CMD_ENCODE: state_in = S_EN_RD;
                  CMD_DECODE: state_in = S_DE_RD;
                  CMD_DIST:   state_in = S_DI_RD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            if (stat.cnt_at_max) state_in = S_IDLE;
         end
         S_TR_RD:    state_in = S_TR_WR;
         S_TR_WR:    state_in = S_IDLE;
         S_FIN_RD:   state_in = S_FIN_CAP;
         S_FIN_CAP:  state_in = S_FIN_WAIT;
         S_FIN_WAIT: begin
            if (stat.div_done) state_in = S_FIN_WR;
         end
         S_FIN_WR:   state_in = stat.cnt_at_eff ? S_IDLE : S_FIN_RD;
         S_EN_RD:    state_in = S_EN_CAP;
         S_EN_CAP:   state_in = S_EN_WAIT;
         S_EN_WAIT: begin
            if (stat.div_done) state_in = S_EN_OUT;
         end
         S_EN_OUT:   state_in = S_IDLE;
         S_DE_RD:    state_in = S_DE_MUL;
         S_DE_MUL:   state_in = S_DE_OUT;
         S_DE_OUT:   state_in = S_IDLE;
         S_DI_RD:    state_in = S_DI_P;
         S_DI_P:     state_in = S_DI_M0;
         S_DI_M0:    state_in = S_DI_M1;
         S_DI_M1:    state_in = S_DI_M2;
         S_DI_M2:    state_in = S_DI_ACC;
         S_DI_ACC:   state_in = S_DI_SUM;
         S_DI_SUM:   state_in = S_DI_OUT;
         S_DI_OUT:   state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath commands for the current state
   always_comb begin
      ctl      = '0;
      ctl.load = accept;
      case (state_ff)
         S_CLEAR: begin
            ctl.use_cnt = 1'b1;
            ctl.clr_wr  = 1'b1;
            ctl.cnt_inc = 1'b1;
         end
         S_INIT: begin
            ctl.use_cnt = 1'b1;
            ctl.init_wr = 1'b1;
            ctl.cnt_inc = 1'b1;
         end
         S_TR_WR:   ctl.train_wr = 1'b1;
         S_FIN_RD:  ctl.use_cnt  = 1'b1;
         S_FIN_CAP: begin
            ctl.use_cnt = 1'b1;
            ctl.fin_cap = 1'b1;
         end
         S_FIN_WAIT: ctl.use_cnt = 1'b1;
         S_FIN_WR: begin
            ctl.use_cnt = 1'b1;
            ctl.fin_wr  = 1'b1;
            ctl.cnt_inc = 1'b1;
         end
         S_EN_CAP:  ctl.enc_cap = 1'b1;
         S_EN_OUT:  ctl.enc_out = 1'b1;
         S_DE_MUL:  ctl.dec_mul = 1'b1;
         S_DE_OUT:  ctl.dec_out = 1'b1;
         S_DI_P:    ctl.dist_p  = 1'b1;
         S_DI_M0: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_LO_LO;
         end
         S_DI_M1: begin
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_HI_LO;
            ctl.acc_load = 1'b1;
         end
         S_DI_M2: begin
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_HI_HI;
            ctl.acc_add1 = 1'b1;
         end
         S_DI_ACC:  ctl.acc_add2 = 1'b1;
         S_DI_SUM:  ctl.dist_sum = 1'b1;
         S_DI_OUT:  ctl.dist_out = 1'b1;
         default: begin
         end
      endcase
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

   // checks
   `SVQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept && state_in != S_IDLE, busy_ff)
   `SVQ_ASSERT_IMPL(a_wait_no_accept, clock, reset, state_ff == S_FIN_WAIT || state_ff == S_EN_WAIT, busy_ff)
   `SVQ_ASSERT_IMPL(a_idle_ready, clock, reset, state_ff == S_IDLE, !busy_ff)

endmodule

// ----- design/scalar_vector_quantizer.sv -----
// Scalar vector quantizer top level: controller plus datapath.
// Encode waits on the bit-serial divider; begin train sweeps all MAX_DIMS entries of
// the running min and max tables, and finish steps through each dimension in use.
// One item at a time; busy marks work. Synchronous reset, then a clearing pass over
// all MAX_DIMS entries of the min and scale tables with busy high; results are
// strobed for one cycle and cannot be stalled.
module scalar_vector_quantizer import svq_pkg::*; #(
   parameter int MAX_DIMS        = MAX_DIMS_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  svq_req_type       req_data,
   output logic              rsp_strobe,
   output svq_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [DIMS_W-1:0] csr_wr_data
);

   svq_ctl_type  ctl;
   svq_stat_type stat;

   // sequencing
   svq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_data.cmd),
      .busy(busy), .ctl(ctl), .stat(stat));

   // arithmetic and storage
   svq_datapath #(.MAX_DIMS(MAX_DIMS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_datapath (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat), .req_data(req_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));

endmodule

// ----- dv/scalar_vector_quantizer_tb.sv -----
// self-checking testbench of the scalar vector quantizer: directed table, then random phases
// of train, finish, encode, decode and distance, checked against a bit-exact predictor
// depends on svq_pkg and scalar_vector_quantizer
module scalar_vector_quantizer_tb;
   import svq_pkg::*;

   localparam int          NDIM       = MAX_DIMS_DEF;
   localparam logic [2:0]  CMD_SPARE6 = 3'd6;
   localparam logic [2:0]  CMD_SPARE7 = 3'd7;
   localparam int          ITEM_GOAL  = 1400;

   typedef struct {
      svq_req_type req;
      bit          typed;
      svq_rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   svq_req_type       req_data;
   logic              rsp_strobe;
   svq_rsp_type       rsp_data;
   logic              csr_wr_en;
   logic [DIMS_W-1:0] csr_wr_data;

   // predictor state
   int signed   min_tab [NDIM];
   logic [47:0] scale_tab [NDIM];
   int signed   run_lo [NDIM];
   int signed   run_hi [NDIM];
   bit          seen_smp;
   bit          began;
   logic [63:0] dist_sum;
   logic [10:0] dims_reg;

   svq_rsp_type expected_q[$];
   int          n_items, n_results, n_mism, n_fail, n_cfg, burst_left;

   scalar_vector_quantizer u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #(4 * 3_000_000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int eff_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > NDIM) return NDIM;
      return int'(dims_reg);
   endfunction

   function automatic logic [47:0] step_of(int signed lo, int signed hi);
      longint      range;
      logic [63:0] num, sc;
      range = longint'(hi) - longint'(lo);
      if (range <= 0) return 48'h1_0000_0000;
      num = 64'(range) << 16;
      sc  = (2 * num + 64'd255) / 64'd510;
      if (sc < 1) sc = 1;
      if (sc > 64'hFFFF_FFFF_FFFF) sc = 64'hFFFF_FFFF_FFFF;
      return sc[47:0];
   endfunction

   // quantizer behaviour for one accepted transfer
   task automatic quantize_predict(input svq_req_type r, output bit has,
                                   output svq_rsp_type o);
      int signed   mn;
      logic [63:0] sc, num, q, p;
      longint      diff, v;
      logic [127:0] sq;
      logic [63:0] term;
      logic [64:0] tot;
      logic [7:0]  ad;
      mn  = min_tab[r.dim_index];
      sc  = {16'b0, scale_tab[r.dim_index]};
      has = 1'b0;
      o   = '0;
      case (r.cmd)
         CMD_BEGIN: begin
            foreach (run_lo[d]) begin
               run_lo[d] = 32'sh7FFF_FFFF;
               run_hi[d] = 32'sh8000_0000;
            end
            seen_smp = 1'b0;
         end
         CMD_TRAIN: begin
            if (r.dim_index < eff_dims()) begin
               if (r.sample < run_lo[r.dim_index]) run_lo[r.dim_index] = r.sample;
               if (r.sample > run_hi[r.dim_index]) run_hi[r.dim_index] = r.sample;
               seen_smp = 1'b1;
            end
         end
         CMD_FINISH: begin
            if (seen_smp)
               for (int d = 0; d < eff_dims(); d++) begin
                  min_tab[d]   = run_lo[d];
                  scale_tab[d] = step_of(run_lo[d], run_hi[d]);
               end
         end
         CMD_ENCODE: begin
            has           = 1'b1;
            o.result_kind = KIND_CODE;
            diff = longint'(r.sample) - longint'(mn);
            if (sc != 0 && diff > 0) begin
               num    = 64'(diff) << 16;
               q      = (2 * num + sc) / (2 * sc);
               o.code = (q > 255) ? 8'd255 : q[7:0];
            end
         end
         CMD_DECODE: begin
            has           = 1'b1;
            o.result_kind = KIND_VALUE;
            p = {56'b0, r.code_a} * sc;
            p = (p + 64'd32768) >> 16;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            v = longint'(mn) + longint'(p);
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
            o.value = v[31:0];
         end
         CMD_DIST: begin
            if (r.dim_index < eff_dims()) begin
               ad   = (r.code_a >= r.code_b) ? r.code_a - r.code_b : r.code_b - r.code_a;
               p    = {56'b0, ad} * sc;
               sq   = {64'b0, p} * {64'b0, p};
               sq   = sq + (128'd1 << 31);
               term = (sq[127:96] != 0) ? '1 : sq[95:32];
               tot  = {1'b0, dist_sum} + {1'b0, term};
               dist_sum = tot[64] ? '1 : tot[63:0];
            end
            if (r.last) begin
               has           = 1'b1;
               o.result_kind = KIND_DIST;
               o.distance    = dist_sum;
               dist_sum      = '0;
            end
         end
         default: ;
      endcase
   endtask

   // one command transfer, with bursts and gaps on the sending side
   task automatic send_cmd(input svq_req_type r, input bit typed = 0,
                           input svq_rsp_type typed_rsp = '0);
      bit          has;
      svq_rsp_type o;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      quantize_predict(r, has, o);
      if (r.cmd == CMD_BEGIN) began = 1'b1;
      if (has) expected_q.push_back(typed ? typed_rsp : o);
      n_items++;
      if (--burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
         if ($urandom_range(0, 4) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // register write once the block has drained
   task automatic write_dims(input logic [10:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);
      while (busy) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dims_reg = val;
      n_cfg++;
   endtask

   function automatic svq_req_type mk_req(logic [2:0] c, logic [9:0] di, logic [31:0] s,
                                          logic [7:0] a, logic [7:0] b, logic l);
      svq_req_type r;
      r = '{cmd: c, dim_index: di, sample: s, code_a: a, code_b: b, last: l};
      return r;
   endfunction

   // result checking: every strobed result is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_results++;
         if (expected_q.size() == 0) begin
            n_fail++;
            n_mism++;
            if (n_mism <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            svq_rsp_type e;
            e = expected_q.pop_front();
            if (e.result_kind !== rsp_data.result_kind || e.code !== rsp_data.code ||
                e.value !== rsp_data.value || e.distance !== rsp_data.distance) begin
               n_fail++;
               n_mism++;
               if (n_mism <= 10)
                  $display("mismatch: kind %0d/%0d code %0d/%0d value %h/%h dist %h/%h",
                           e.result_kind, rsp_data.result_kind, e.code, rsp_data.code,
                           e.value, rsp_data.value, e.distance, rsp_data.distance);
            end
         end
      end
   end

   stim_row_type dir_rows[22];

   initial begin
      int          n_dim, lim, ntrain, nops, spread, dbg;
      logic [9:0]  di;
      logic [31:0] centre, s;
      logic [2:0]  c;
      logic [10:0] cfg_pick[6];

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      foreach (min_tab[d]) begin
         min_tab[d]   = 0;
         scale_tab[d] = '0;
         run_lo[d]    = 0;
         run_hi[d]    = 0;
      end
      seen_smp   = 0;
      began      = 0;
      dist_sum   = '0;
      dims_reg   = DIMS_RESET;
      burst_left = 5;

      // directed rows: untrained tables, extremes, unsampled and out-of-range dimensions
      dir_rows = '{
         '{mk_req(CMD_ENCODE, 0, 32'h7FFF_FFFF, 0, 0, 0), 1, '{KIND_CODE, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_DECODE, 0, 0, 255, 0, 0), 1, '{KIND_VALUE, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_DIST, 0, 0, 255, 0, 1), 1, '{KIND_DIST, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_SPARE6, 10'h3FF, 32'hFFFF_FFFF, 255, 255, 1), 0, '0},
         '{mk_req(CMD_SPARE7, 0, 0, 0, 0, 0), 0, '0},
         '{mk_req(CMD_BEGIN, 0, 0, 0, 0, 0), 0, '0},
         '{mk_req(CMD_FINISH, 0, 0, 0, 0, 0), 0, '0},
         '{mk_req(CMD_TRAIN, 0, 32'h8000_0000, 0, 0, 0), 0, '0},
         '{mk_req(CMD_TRAIN, 0, 32'h7FFF_FFFF, 0, 0, 0), 0, '0},
         '{mk_req(CMD_TRAIN, 1, 32'd5, 0, 0, 0), 0, '0},
         '{mk_req(CMD_TRAIN, 10'h3FF, 32'd123, 0, 0, 0), 0, '0},
         '{mk_req(CMD_FINISH, 0, 0, 0, 0, 0), 0, '0},
         '{mk_req(CMD_ENCODE, 0, 32'h8000_0000, 0, 0, 0), 1, '{KIND_CODE, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_ENCODE, 0, 32'h7FFF_FFFF, 0, 0, 0), 0, '0},
         '{mk_req(CMD_ENCODE, 1, 32'd5, 0, 0, 0), 1, '{KIND_CODE, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_DECODE, 0, 0, 0, 0, 0), 1, '{KIND_VALUE, 8'd0, 32'h8000_0000, 64'd0}},
         '{mk_req(CMD_DECODE, 0, 0, 255, 0, 0), 0, '0},
         '{mk_req(CMD_DECODE, 2, 0, 255, 0, 0), 1, '{KIND_VALUE, 8'd0, 32'h7FFF_FFFF, 64'd0}},
         '{mk_req(CMD_DIST, 0, 0, 0, 255, 0), 0, '0},
         '{mk_req(CMD_DIST, 10'h3FF, 0, 255, 0, 1), 0, '0},
         '{mk_req(CMD_DIST, 3, 0, 0, 0, 1), 1, '{KIND_DIST, 8'd0, 32'd0, 64'd0}},
         '{mk_req(CMD_ENCODE, 3, 32'h7FFF_FFFF, 0, 0, 0), 0, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_dims(11'd4);
      foreach (dir_rows[i]) send_cmd(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // random phases; the register extremes come first, then mostly small counts
      cfg_pick = '{11'd2047, 11'd0, 11'd1, 11'd1024, 11'd3, 11'd8};
      for (int ph = 0; n_items < ITEM_GOAL; ph++) begin
         write_dims(ph < 6 ? cfg_pick[ph] : 11'($urandom_range(1, 12)));
         n_dim  = eff_dims();
         lim    = (n_dim > 16) ? 16 : n_dim;
         centre = $urandom;
         spread = $urandom_range(4, 31);

         // training: well-formed begin, samples, finish, with some noise
         if (!began || $urandom_range(0, 4) != 0)
            send_cmd(mk_req(CMD_BEGIN, 10'($urandom), $urandom, 8'($urandom), 8'($urandom),
                            1'($urandom)));
         ntrain = $urandom_range(3, 30);
         for (int k = 0; k < ntrain; k++) begin
            di = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, lim - 1));
            s  = ($urandom_range(0, 7) == 0) ? $urandom
                                            : centre + ($signed($urandom) >>> spread);
            send_cmd(mk_req(CMD_TRAIN, di, s, 8'($urandom), 8'($urandom), 1'($urandom)));
         end
         if ($urandom_range(0, 9) != 0)
            send_cmd(mk_req(CMD_FINISH, 10'($urandom), $urandom, 8'($urandom), 8'($urandom),
                            1'($urandom)));

         // use: encode, decode and distance runs, with some spare commands
         nops = $urandom_range(60, 130);
         for (int k = 0; k < nops; k++) begin
            di = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, lim - 1));
            dbg = $urandom_range(0, 19);
            if (dbg < 7) c = CMD_ENCODE;
            else if (dbg < 12) c = CMD_DECODE;
            else if (dbg < 18) c = CMD_DIST;
            else c = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
            s = ($urandom_range(0, 7) == 0) ? $urandom
                                           : centre + ($signed($urandom) >>> (spread - 1));
            send_cmd(mk_req(c, di, s, 8'($urandom), 8'($urandom),
                            (c == CMD_DIST) ? ($urandom_range(0, 3) == 0) : 1'($urandom)));
         end
         send_cmd(mk_req(CMD_DIST, 0, 0, 8'($urandom), 8'($urandom), 1'b1));
      end

      // drain
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (busy) n_fail++;

      $display("covered %0d command transfers, %0d result transfers, %0d register writes",
               n_items, n_results, n_cfg);
      $display("mismatches %0d, failures %0d", n_mism, n_fail);
      if (n_fail == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/svq_pkg.sv
design/svq_ram.sv
design/svq_div.sv
design/svq_datapath.sv
design/svq_ctrl.sv
design/scalar_vector_quantizer.sv
dv/scalar_vector_quantizer_tb.sv
